[design/sfla_pkg.sv]
// Shared types, constants and the block size table of the size class allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sfla_pkg;

  localparam int POOL_BYTES  = 4096;
  localparam int NUM_CLASSES = 16;

  localparam int ADDR_W     = 12;
  localparam int TAIL_W     = 13;
  localparam int CLS_W      = 4;
  localparam int MODE_W     = 2;
  localparam int LEN_W      = 8;
  localparam int LINK_W     = ADDR_W + 1;
  localparam int LINK_DEPTH = 1 << ADDR_W;
  localparam int TAIL_MAX   = (1 << TAIL_W) - 1;
  localparam int POOL_CAP   = (POOL_BYTES > TAIL_MAX) ? TAIL_MAX : POOL_BYTES;
  localparam logic [TAIL_W-1:0] POOL_LIMIT = TAIL_W'(POOL_CAP);
  localparam logic [TAIL_W-1:0] POOL_RESET = TAIL_W'(4096);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_POOL_BYTES = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_REINIT  = 2'd2
  } mode_t;

  localparam logic [LEN_W-1:0] CLASS_LEN [16] = '{
    8'd8, 8'd12, 8'd16, 8'd24, 8'd32, 8'd40, 8'd56, 8'd58,
    8'd64, 8'd70, 8'd80, 8'd96, 8'd112, 8'd128, 8'd160, 8'd192
  };

  typedef struct packed {
    logic accept;
    logic load_head;
  } sfla_cmd_t;

  typedef struct packed {
    logic pop;
  } sfla_sts_t;

endpackage

`default_nettype wire

[design/sfla_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Stands alone; holds the free list links of the allocator.
`default_nettype none

module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/sfla_ctrl.sv]
// Controller of the allocator: handshake on both channels and the pop sequence.
// Depends on sfla_pkg for the command and status types.
`default_nettype none

module sfla_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire sfla_pkg::sfla_sts_t sts,
  output sfla_pkg::sfla_cmd_t      cmd
);

  import sfla_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LINK = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.accept    = accept;
    cmd.load_head = (state_r == ST_LINK);
  end

  always_comb begin
    case (state_r)
      ST_IDLE: begin
        state_nxt = (accept && sts.pop) ? ST_LINK : ST_IDLE;
      end
      ST_LINK: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[design/sfla_dp.sv]
// Datapath of the allocator: list heads, tail pointer, pool limit register,
// link memory and result registers. Depends on sfla_pkg and sfla_ram.
`default_nettype none

module sfla_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire sfla_pkg::sfla_cmd_t             cmd,
  output sfla_pkg::sfla_sts_t                  sts,
  input  wire logic [sfla_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [sfla_pkg::CLS_W-1:0]      in_size_class,
  input  wire logic [sfla_pkg::ADDR_W-1:0]     in_release_addr,
  output logic      [sfla_pkg::ADDR_W-1:0]     out_block_addr,
  output logic                                 out_status,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [sfla_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [sfla_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [sfla_pkg::CFG_DATA_W-1:0] cfg_prdata
);

  import sfla_pkg::*;

  logic              head_vld_r  [NUM_CLASSES];
  logic [ADDR_W-1:0] head_addr_r [NUM_CLASSES];
  logic [TAIL_W-1:0] tail_r, tail_nxt;
  logic [TAIL_W-1:0] pool_bytes_r;
  logic [CLS_W-1:0]  pop_cls_r;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic              out_status_r, out_status_nxt;

  logic              cls_ok;
  logic              sel_vld;
  logic [ADDR_W-1:0] sel_addr;
  logic [TAIL_W-1:0] limit;
  logic [TAIL_W:0]   carve_end;
  logic              carve_fit;
  logic              is_alloc, is_release, is_reinit;
  logic              do_pop, do_push;
  logic [LINK_W-1:0] link_rdata;
  logic              cfg_wr;

  assign cls_ok   = ({1'b0, in_size_class} < (CLS_W + 1)'(NUM_CLASSES));
  assign sel_vld  = cls_ok ? head_vld_r[in_size_class] : 1'b0;
  assign sel_addr = cls_ok ? head_addr_r[in_size_class] : '0;

  assign limit     = (pool_bytes_r > POOL_LIMIT) ? POOL_LIMIT : pool_bytes_r;
  assign carve_end = {1'b0, tail_r} + (TAIL_W + 1)'(CLASS_LEN[in_size_class]);
  assign carve_fit = (carve_end <= {1'b0, limit});

  always_comb begin
    is_alloc   = 1'b0;
    is_release = 1'b0;
    is_reinit  = 1'b0;
    case (mode_t'(in_mode))
      MODE_ALLOC:   is_alloc   = 1'b1;
      MODE_RELEASE: is_release = 1'b1;
      MODE_REINIT:  is_reinit  = 1'b1;
      default:      is_alloc   = 1'b0;
    endcase
  end

  assign do_pop  = is_alloc && cls_ok && sel_vld;
  assign do_push = is_release && cls_ok;
  assign sts.pop = do_pop;

  always_comb begin
    out_addr_nxt   = '0;
    out_status_nxt = 1'b0;
    tail_nxt       = tail_r;
    if (is_alloc) begin
      if (!cls_ok) begin
        out_status_nxt = 1'b1;
      end else if (sel_vld) begin
        out_addr_nxt = sel_addr;
      end else if (carve_fit) begin
        out_addr_nxt = tail_r[ADDR_W-1:0];
        tail_nxt     = carve_end[TAIL_W-1:0];
      end else begin
        out_status_nxt = 1'b1;
      end
    end else if (is_reinit) begin
      tail_nxt = '0;
    end
  end

  sfla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (cmd.accept && do_push),
    .waddr (in_release_addr),
    .wdata ({sel_vld, sel_addr}),
    .re    (cmd.accept && do_pop),
    .raddr (sel_addr),
    .rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_vld_r[i] <= 1'b0;
      end
    end else if (cmd.load_head) begin
      head_vld_r[pop_cls_r] <= link_rdata[LINK_W-1];
    end else if (cmd.accept && is_reinit) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_vld_r[i] <= 1'b0;
      end
    end else if (cmd.accept && do_push) begin
      head_vld_r[in_size_class] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_head) begin
      head_addr_r[pop_cls_r] <= link_rdata[ADDR_W-1:0];
    end else if (cmd.accept && do_push) begin
      head_addr_r[in_size_class] <= in_release_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pop_cls_r    <= in_size_class;
      out_addr_r   <= out_addr_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[CFG_ADDR_W-1] == REG_POOL_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r       <= '0;
      pool_bytes_r <= POOL_RESET;
    end else begin
      if (cmd.accept) begin
        tail_r <= tail_nxt;
      end
      if (cfg_wr) begin
        pool_bytes_r <= cfg_pwdata[TAIL_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_POOL_BYTES) ?
                      CFG_DATA_W'(pool_bytes_r) : '0;

  assign out_block_addr = out_addr_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

[design/size_class_free_list_allocator.sv]
// Top level of the size class free list allocator.
// Depends on sfla_pkg, sfla_ctrl, sfla_dp and, through the datapath, sfla_ram.
//
// The block hands out byte offsets from a pool in sixteen fixed block sizes
// from 8 to 192 bytes, keeping one free list per size class and carving fresh
// blocks from the unused tail of the pool when a list is empty. Every item
// gives exactly one result. An allocate that pops a free list holds off new
// items while the next list entry is read from the link memory, whose read
// data is registered, and the list head is updated; other items do not. A
// new item is also held off while the previous result waits to be taken. The
// link memory needs no clearing after reset, so the block takes items as soon
// as reset is released. The pool_bytes register, at any address with bit 2 of
// cfg_paddr clear, limits how far the tail may grow; lowering it stops further
// carving but leaves the free lists in service.
`default_nettype none

module size_class_free_list_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [sfla_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [sfla_pkg::CLS_W-1:0]      in_size_class,
  input  wire logic [sfla_pkg::ADDR_W-1:0]     in_release_addr,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [sfla_pkg::ADDR_W-1:0]     out_block_addr,
  output logic                                 out_status,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [sfla_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [sfla_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [sfla_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);

  import sfla_pkg::*;

  sfla_cmd_t cmd;
  sfla_sts_t sts;

  assign cfg_pready = 1'b1;

  sfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfla_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_size_class   (in_size_class),
    .in_release_addr (in_release_addr),
    .out_block_addr  (out_block_addr),
    .out_status      (out_status),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata)
  );

endmodule

`default_nettype wire
